[design/mlcp_pkg.sv]
// Shared types, label table and character codes of the meter line parser.
package mlcp_pkg;

	typedef logic [4:0] label_idx_t;
	typedef logic [3:0] val_width_t;

	localparam int          NUM_LABELS    = 18;
	localparam int          NUM_IDENT     = 3;
	localparam label_idx_t  LABEL_NONE    = 5'd18;
	localparam label_idx_t  LABEL_PTEC    = 5'd14;
	localparam int          LABEL_MAX_LEN = 8;

	localparam logic [7:0]  CHAR_NUL   = 8'h00;
	localparam logic [7:0]  CHAR_LF    = 8'h0A;
	localparam logic [7:0]  CHAR_CR    = 8'h0D;
	localparam logic [7:0]  CHAR_SPACE = 8'h20;
	localparam logic [7:0]  CHAR_ZERO  = 8'h30;
	localparam logic [7:0]  CHAR_NINE  = 8'h39;
	localparam logic [7:0]  CSUM_BIAS  = 8'h20;

	localparam logic [29:0] NUMBER_CAP = 30'd999999999;
	localparam logic [7:0]  REPORT_INTERVAL_RST = 8'd20;

	// label names packed right-justified, first character in the highest used byte
	localparam logic [63:0] LABEL_NAMES [NUM_LABELS] = '{
		64'h0000_0000_4144_434F,  // ADCO
		64'h004F_5054_4152_4946,  // OPTARIF
		64'h0000_4953_4F55_5343,  // ISOUSC
		64'h0000_0000_4241_5345,  // BASE
		64'h0000_0000_4843_4843,  // HCHC
		64'h0000_0000_4843_4850,  // HCHP
		64'h0000_454A_5048_504D,  // EJPHPM
		64'h0000_0045_4A50_484E,  // EJPHN
		64'h0042_4252_4843_4A42,  // BBRHCJB
		64'h0042_4252_4850_4A42,  // BBRHPJB
		64'h0042_4252_4843_4A57,  // BBRHCJW
		64'h0042_4252_4850_4A57,  // BBRHPJW
		64'h0042_4252_4843_4A52,  // BBRHCJR
		64'h0042_4252_4850_4A52,  // BBRHPJR
		64'h0000_0000_5054_4543,  // PTEC
		64'h0000_0049_494E_5354,  // IINST
		64'h0000_0000_494D_4158,  // IMAX
		64'h0000_0000_5041_5050   // PAPP
	};

	localparam val_width_t VALUE_WIDTHS [NUM_LABELS] = '{
		4'd12, 4'd4, 4'd2, 4'd9, 4'd9, 4'd9, 4'd9, 4'd9, 4'd9,
		4'd9,  4'd9, 4'd9, 4'd9, 4'd9, 4'd4, 4'd3, 4'd3, 4'd5
	};

	function automatic label_idx_t label_lookup(input logic [63:0] chars);
		label_idx_t idx;
		idx = LABEL_NONE;
		if (chars != 64'd0) begin
			for (int i = 0; i < NUM_LABELS; i++) begin
				if (chars == LABEL_NAMES[i]) begin
					idx = label_idx_t'(i);
				end
			end
		end
		return idx;
	endfunction

endpackage

[design/mlcp_ifs.sv]
// Valid/ready channel interfaces: received bytes, configuration writes, line results.
interface mlcp_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

interface mlcp_cfg_if;
	logic       valid;
	logic       ready;
	logic [7:0] report_interval;

	modport source (output valid, output report_interval, input ready);
	modport sink (input valid, input report_interval, output ready);
endinterface

interface mlcp_result_if;
	logic        valid;
	logic        ready;
	logic [4:0]  label_index;
	logic        checksum_ok;
	logic [29:0] number_value;
	logic [31:0] text_value;
	logic        report;

	modport source (output valid, output label_index, output checksum_ok,
		output number_value, output text_value, output report, input ready);
	modport sink (input valid, input label_index, input checksum_ok,
		input number_value, input text_value, input report, output ready);
endinterface

[design/meter_line_checksum_parser_core.sv]
// Meter line parser: byte stream in, one checksum/label/value result per completed line.
//
//   channel  dir   request payload                                   handshake
//   rx       in    rx_byte                                           valid/ready
//   cfg      in    report_interval                                   valid/ready
//   res      out   label_index checksum_ok number_value text_value   valid/ready
//                  report
//
// One byte per cycle sustained unless a line end stalls; a byte is registered, then
// folded into the line state, and a line end loads the result register at that step.
// Reset clears the line state, the per-label counters and identity flags.
// A line end stalls only while the result register is still full and not taken.
// cfg is always ready.
module meter_line_checksum_parser_core #(
	parameter int LINE_MAX = 64
) (
	input  logic                 clk,
	input  logic                 arst_n,
	mlcp_byte_if.sink            rx,
	mlcp_cfg_if.sink             cfg,
	mlcp_result_if.source        res
);
	import mlcp_pkg::*;

	localparam int             LEN_W     = $clog2(LINE_MAX);
	localparam logic [LEN_W-1:0] LINE_LAST = LEN_W'(LINE_MAX - 1);

	// input stage
	logic             valid_s1;
	logic [7:0]       byte_s1;

	// line state
	logic [LEN_W-1:0] line_len_q;
	logic [5:0]       sum_q;
	logic [15:0]      last_two_q;
	logic [63:0]      label_q;
	logic             past_q;
	label_idx_t       label_idx_q;
	logic [3:0]       taken_q;
	logic [29:0]      num_q;
	logic [31:0]      text_q;
	logic             digits_done_q;

	logic [7:0]       counters_q [NUM_LABELS];
	logic [NUM_IDENT-1:0] ident_seen_q;
	logic [7:0]       interval_q;

	logic             out_valid_q;

	// next-state
	logic [LEN_W-1:0] line_len_d;
	logic [5:0]       sum_d;
	logic [15:0]      last_two_d;
	logic [63:0]      label_d;
	logic             past_d;
	label_idx_t       label_idx_d;
	logic [3:0]       taken_d;
	logic [29:0]      num_d;
	logic [31:0]      text_d;
	logic             digits_done_d;

	logic             skip, line_end, emit, advance, csum_ok, hit, due;
	logic             is_digit;
	logic [33:0]      num_next;
	logic [7:0]       cnt_rd;
	logic [7:0]       cnt_new;
	logic             rep;

	assign skip     = (byte_s1 == CHAR_CR) || (byte_s1 == CHAR_NUL);
	assign line_end = (byte_s1 == CHAR_LF) || (line_len_q == LINE_LAST);
	assign emit     = valid_s1 && !skip && line_end && (line_len_q != '0);
	assign advance  = valid_s1 && (!emit || !out_valid_q || res.ready);

	assign rx.ready  = !valid_s1 || advance;
	assign cfg.ready = 1'b1;

	assign csum_ok = (8'({2'b00, sum_q}) + CSUM_BIAS) == last_two_q[7:0];
	assign hit     = csum_ok && past_q && (label_idx_q != LABEL_NONE);
	assign cnt_rd  = counters_q[label_idx_q];
	assign is_digit = (byte_s1 >= CHAR_ZERO) && (byte_s1 <= CHAR_NINE);
	assign num_next = (34'(num_q) << 3) + (34'(num_q) << 1) + 34'(byte_s1[3:0]);

	always_comb begin
		due = (cnt_rd >= interval_q) && ((label_idx_q == LABEL_PTEC) || (num_q != '0));
		if (label_idx_q < label_idx_t'(NUM_IDENT)) begin
			rep = !ident_seen_q[label_idx_q[1:0]];
		end else begin
			rep = due;
		end
		cnt_new = due ? 8'd1 : cnt_rd + 8'd1;
	end

	always_comb begin
		line_len_d    = line_len_q;
		sum_d         = sum_q;
		last_two_d    = last_two_q;
		label_d       = label_q;
		past_d        = past_q;
		label_idx_d   = label_idx_q;
		taken_d       = taken_q;
		num_d         = num_q;
		text_d        = text_q;
		digits_done_d = digits_done_q;
		if (!skip && line_end) begin
			line_len_d    = '0;
			sum_d         = '0;
			last_two_d    = '0;
			label_d       = '0;
			past_d        = 1'b0;
			label_idx_d   = LABEL_NONE;
			taken_d       = '0;
			num_d         = '0;
			text_d        = '0;
			digits_done_d = 1'b0;
		end else if (!skip) begin
			if (line_len_q >= LEN_W'(2)) begin
				sum_d = sum_q + last_two_q[13:8];
			end
			last_two_d = {last_two_q[7:0], byte_s1};
			if (!past_q) begin
				if (byte_s1 == CHAR_SPACE) begin
					past_d = 1'b1;
					if (line_len_q > LEN_W'(LABEL_MAX_LEN)) begin
						label_d     = '0;
						label_idx_d = LABEL_NONE;
					end else begin
						label_idx_d = label_lookup(label_q);
					end
				end else begin
					label_d = {label_q[55:0], byte_s1};
				end
			end else if (label_idx_q != LABEL_NONE &&
					taken_q < VALUE_WIDTHS[label_idx_q]) begin
				if (taken_q < 4'd4) begin
					text_d = text_q | (32'(byte_s1) << {~taken_q[1:0], 3'b000});
				end
				if (!digits_done_q) begin
					if (is_digit) begin
						num_d = (num_next > 34'(NUMBER_CAP)) ? NUMBER_CAP : num_next[29:0];
					end else begin
						digits_done_d = 1'b1;
					end
				end
				taken_d = taken_q + 4'd1;
			end
			line_len_d = line_len_q + LEN_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx.ready) begin
			valid_s1 <= rx.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx.valid && rx.ready) begin
			byte_s1 <= rx.rx_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_len_q    <= '0;
			sum_q         <= '0;
			last_two_q    <= '0;
			label_q       <= '0;
			past_q        <= 1'b0;
			label_idx_q   <= LABEL_NONE;
			taken_q       <= '0;
			num_q         <= '0;
			text_q        <= '0;
			digits_done_q <= 1'b0;
		end else if (advance) begin
			line_len_q    <= line_len_d;
			sum_q         <= sum_d;
			last_two_q    <= last_two_d;
			label_q       <= label_d;
			past_q        <= past_d;
			label_idx_q   <= label_idx_d;
			taken_q       <= taken_d;
			num_q         <= num_d;
			text_q        <= text_d;
			digits_done_q <= digits_done_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_LABELS; i++) begin
				counters_q[i] <= '0;
			end
			ident_seen_q <= '0;
		end else if (advance && emit && hit) begin
			if (label_idx_q < label_idx_t'(NUM_IDENT)) begin
				ident_seen_q[label_idx_q[1:0]] <= 1'b1;
			end else begin
				counters_q[label_idx_q] <= cnt_new;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			interval_q <= REPORT_INTERVAL_RST;
		end else if (cfg.valid && cfg.ready) begin
			interval_q <= cfg.report_interval;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && emit) begin
			out_valid_q <= 1'b1;
		end else if (res.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && emit) begin
			res.checksum_ok <= csum_ok;
			if (hit) begin
				res.label_index  <= label_idx_q;
				res.number_value <= num_q;
				res.text_value   <= text_q;
				res.report       <= rep;
			end else begin
				res.label_index  <= LABEL_NONE;
				res.number_value <= '0;
				res.text_value   <= '0;
				res.report       <= 1'b0;
			end
		end
	end

	assign res.valid = out_valid_q;

	// known label only comes with a good checksum
	a_label_needs_csum: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid |-> (res.label_index == LABEL_NONE || res.checksum_ok))
		else $error("label reported on bad checksum");

	a_none_is_blank: assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && res.label_index == LABEL_NONE) |->
		(res.number_value == '0 && res.text_value == '0 && !res.report))
		else $error("payload on unknown line");

	a_number_cap: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid |-> (res.number_value <= NUMBER_CAP))
		else $error("number above cap");

	a_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		line_len_q <= LINE_LAST)
		else $error("line length overrun");

	a_empty_after_end: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && emit) |=> (line_len_q == '0 && !past_q))
		else $error("line state not cleared after result");

endmodule

[test/tb_meter_line_checksum_parser_core.sv]
// Testbench of the meter line parser: byte stream stimulus against a line predictor.
`timescale 1ns / 1ps

module tb_meter_line_checksum_parser_core;
	import mlcp_pkg::*;

	localparam int LINE_MAX    = 64;
	localparam int CYCLE_LIMIT = 300000;
	localparam int PHASE_BYTES = 255;

	typedef struct packed {
		label_idx_t  label_index;
		logic        checksum_ok;
		logic [29:0] number_value;
		logic [31:0] text_value;
		logic        report;
	} line_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	mlcp_byte_if   rx_if ();
	mlcp_cfg_if    cfg_if ();
	mlcp_result_if res_if ();

	logic       rx_valid = 1'b0;
	logic [7:0] rx_data = 8'h00;
	logic       cfg_valid = 1'b0;
	logic [7:0] cfg_data = 8'h00;
	logic       res_ready = 1'b0;

	assign rx_if.valid = rx_valid;
	assign rx_if.rx_byte = rx_data;
	assign cfg_if.valid = cfg_valid;
	assign cfg_if.report_interval = cfg_data;
	assign res_if.ready = res_ready;

	meter_line_checksum_parser_core #(.LINE_MAX(LINE_MAX)) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.rx     (rx_if),
		.cfg    (cfg_if),
		.res    (res_if)
	);

	// label table of the meter protocol, in result index order
	string known_labels [NUM_LABELS] = '{
		"ADCO", "OPTARIF", "ISOUSC", "BASE", "HCHC", "HCHP", "EJPHPM", "EJPHN",
		"BBRHCJB", "BBRHPJB", "BBRHCJW", "BBRHPJW", "BBRHCJR", "BBRHPJR",
		"PTEC", "IINST", "IMAX", "PAPP"
	};
	int field_width [NUM_LABELS] = '{12, 4, 2, 9, 9, 9, 9, 9, 9, 9, 9, 9, 9, 9, 4, 3, 3, 5};

	// line parser state as predicted
	int unsigned m_len = 0;
	logic [15:0] m_sum = '0;
	logic [15:0] m_last2 = '0;
	logic [63:0] m_label = '0;
	bit          m_space = 1'b0;
	bit          m_digits_done = 1'b0;
	int unsigned m_taken = 0;
	logic [29:0] m_num = '0;
	logic [31:0] m_text = '0;
	logic [7:0]  m_count [NUM_LABELS] = '{default: 8'h00};
	bit          m_ident [NUM_IDENT] = '{default: 1'b0};
	logic [7:0]  m_interval = REPORT_INTERVAL_RST;

	line_result_t expected_lines [$];
	logic [7:0]   tx_bytes [$];
	logic [7:0]   line_buf [$];
	int           phase_bytes = 0;
	int           src_idle = 15;
	int           rcv_idle = 69;
	int           mismatches = 0;
	int           cycles = 0;

	function automatic void buf_char(logic [7:0] c);
		line_buf.insert(line_buf.size(), c);
	endfunction

	function automatic logic [63:0] pack_name(string s);
		logic [63:0] v;
		v = '0;
		for (int i = 0; i < s.len() && i < 8; i++)
			v = {v[55:0], 8'(s[i])};
		return v;
	endfunction

	function automatic label_idx_t find_label(logic [63:0] chars);
		label_idx_t idx;
		idx = LABEL_NONE;
		if (chars != '0) begin
			for (int i = NUM_LABELS - 1; i >= 0; i--)
				if (pack_name(known_labels[i]) == chars)
					idx = label_idx_t'(i);
		end
		return idx;
	endfunction

	function automatic void clear_line();
		m_len = 0;
		m_sum = '0;
		m_last2 = '0;
		m_label = '0;
		m_space = 1'b0;
		m_digits_done = 1'b0;
		m_taken = 0;
		m_num = '0;
		m_text = '0;
	endfunction

	function automatic void take_char(logic [7:0] c);
		label_idx_t idx;
		longint unsigned n;
		if (m_len >= 2)
			m_sum = m_sum + {8'h00, m_last2[15:8]};
		m_last2 = {m_last2[7:0], c};
		if (!m_space) begin
			if (c == CHAR_SPACE) begin
				m_space = 1'b1;
				if (m_len > LABEL_MAX_LEN)
					m_label = '0;
			end else begin
				m_label = {m_label[55:0], c};
			end
		end else begin
			idx = find_label(m_label);
			if (idx != LABEL_NONE && m_taken < field_width[idx]) begin
				if (m_taken < 4)
					m_text = m_text | (32'(c) << (24 - 8 * m_taken));
				if (!m_digits_done) begin
					if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
						n = 64'(m_num) * 10 + 64'(c - CHAR_ZERO);
						m_num = (n > 64'(NUMBER_CAP)) ? NUMBER_CAP : 30'(n);
					end else begin
						m_digits_done = 1'b1;
					end
				end
				m_taken++;
			end
		end
		m_len++;
	endfunction

	function automatic void parse_byte(logic [7:0] c);
		line_result_t r;
		label_idx_t   idx;
		bit           due;
		if (c == CHAR_CR || c == CHAR_NUL)
			return;
		if (c != CHAR_LF && m_len < LINE_MAX - 1) begin
			take_char(c);
			return;
		end
		if (m_len == 0) begin
			clear_line();
			return;
		end
		r = '0;
		r.label_index = LABEL_NONE;
		r.checksum_ok = ({2'b00, m_sum[5:0]} + CSUM_BIAS) == m_last2[7:0];
		if (r.checksum_ok && m_space) begin
			idx = find_label(m_label);
			if (idx != LABEL_NONE) begin
				r.label_index = idx;
				r.number_value = m_num;
				r.text_value = m_text;
				if (idx < NUM_IDENT) begin
					r.report = !m_ident[idx];
					m_ident[idx] = 1'b1;
				end else begin
					due = m_count[idx] >= m_interval;
					if (idx != LABEL_PTEC && m_num == '0)
						due = 1'b0;
					if (due) begin
						r.report = 1'b1;
						m_count[idx] = 8'h00;
					end
					m_count[idx] = m_count[idx] + 8'h01;
				end
			end
		end
		expected_lines.insert(expected_lines.size(), r);
		clear_line();
	endfunction

	// byte driver
	always @(posedge clk) begin
		if (!arst_n) begin
			rx_valid <= 1'b0;
		end else if (!rx_valid || rx_if.ready) begin
			if (tx_bytes.size() != 0 && $urandom_range(99) >= src_idle) begin
				rx_valid <= 1'b1;
				rx_data <= tx_bytes.pop_front();
			end else begin
				rx_valid <= 1'b0;
			end
		end
	end

	// accepted bytes feed the predictor, accepted results are checked
	always @(posedge clk) begin
		line_result_t want;
		line_result_t got;
		if (!arst_n) begin
			res_ready <= 1'b0;
		end else begin
			res_ready <= ($urandom_range(99) >= rcv_idle);
			if (rx_if.valid && rx_if.ready)
				parse_byte(rx_if.rx_byte);
			if (res_if.valid && res_if.ready) begin
				got.label_index = res_if.label_index;
				got.checksum_ok = res_if.checksum_ok;
				got.number_value = res_if.number_value;
				got.text_value = res_if.text_value;
				got.report = res_if.report;
				if (expected_lines.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected line result: label %0d ok %0b num %0d text %h rep %0b",
							got.label_index, got.checksum_ok, got.number_value,
							got.text_value, got.report);
				end else begin
					want = expected_lines.pop_front();
					if (got.label_index !== want.label_index
							|| got.checksum_ok !== want.checksum_ok
							|| got.number_value !== want.number_value
							|| got.text_value !== want.text_value
							|| got.report !== want.report) begin
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch exp %0d/%0b/%0d/%h/%0b got %0d/%0b/%0d/%h/%0b",
								want.label_index, want.checksum_ok, want.number_value,
								want.text_value, want.report, got.label_index,
								got.checksum_ok, got.number_value, got.text_value,
								got.report);
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// skipped bytes are sprinkled in now and then
	task automatic emit(logic [7:0] c);
		if ($urandom_range(99) < 3)
			tx_bytes.insert(tx_bytes.size(), $urandom_range(1) ? CHAR_CR : CHAR_NUL);
		tx_bytes.insert(tx_bytes.size(), c);
		phase_bytes++;
	endtask

	task automatic add_text(string s);
		for (int i = 0; i < s.len(); i++)
			buf_char(8'(s[i]));
	endtask

	task automatic send_line(bit spoil);
		logic [15:0] sum;
		logic [7:0]  cs;
		sum = '0;
		foreach (line_buf[i])
			sum = sum + {8'h00, line_buf[i]};
		cs = {2'b00, sum[5:0]} + CSUM_BIAS;
		if (spoil)
			cs = CSUM_BIAS + 8'((cs - CSUM_BIAS + 1 + $urandom_range(62)) % 64);
		foreach (line_buf[i])
			emit(line_buf[i]);
		emit(CHAR_SPACE);
		emit(cs);
		if ($urandom_range(1))
			emit(CHAR_CR);
		emit(CHAR_LF);
		line_buf.delete();
	endtask

	task automatic send_raw();
		foreach (line_buf[i])
			emit(line_buf[i]);
		emit(CHAR_LF);
		line_buf.delete();
	endtask

	task automatic add_value(int kind, int len);
		logic [7:0] c;
		for (int i = 0; i < len; i++) begin
			case (kind)
				0: c = CHAR_ZERO + 8'($urandom_range(9));
				1: c = CHAR_ZERO;
				2: c = 8'($urandom_range(8'h21, 8'h7E));
				default: begin
					do c = 8'($urandom_range(1, 255)); while (c == CHAR_LF || c == CHAR_CR);
				end
			endcase
			buf_char(c);
		end
	endtask

	task automatic directed_lines();
		add_text("ADCO 123456789012");
		send_line(1'b0);
		add_text("ADCO 000000000001");
		send_line(1'b0);
		add_text("OPTARIF BASE");
		send_line(1'b0);
		add_text("PTEC HP..");
		send_line(1'b0);
		add_text("IINST 005");
		send_line(1'b0);
		add_text("PAPP 01230");
		send_line(1'b1);
		add_text("FOO 12");
		send_line(1'b0);
		add_text("XBBRHCJBX 12");
		send_line(1'b0);
		add_text("BASE X12345");
		send_line(1'b0);
		add_text("HCHC 12");
		send_line(1'b0);
		emit(CHAR_LF);
		emit(CHAR_NUL);
		emit(CHAR_CR);
		emit(CHAR_LF);
		add_text("NOSPACE");
		send_raw();
		buf_char(8'hFF);
		buf_char(8'h80);
		buf_char(8'h7F);
		buf_char(8'h01);
		send_raw();
	endtask

	task automatic random_lines(int budget);
		int pick;
		int idx;
		int kind;
		phase_bytes = 0;
		while (phase_bytes < budget) begin
			pick = $urandom_range(99);
			if (pick < 70) begin
				if ($urandom_range(1)) begin
					case ($urandom_range(5))
						0: idx = 0;
						1: idx = 3;
						2: idx = 14;
						3: idx = 15;
						4: idx = 17;
						default: idx = 8;
					endcase
				end else begin
					idx = $urandom_range(NUM_LABELS - 1);
				end
				kind = $urandom_range(99);
				add_text(known_labels[idx]);
				buf_char(CHAR_SPACE);
				if (kind < 65)
					add_value(0, $urandom_range(0, 12));
				else if (kind < 80)
					add_value(1, $urandom_range(1, 12));
				else
					add_value(2, $urandom_range(1, 8));
				send_line($urandom_range(99) < 10);
			end else if (pick < 80) begin
				for (int i = $urandom_range(1, 11); i > 0; i--)
					buf_char(8'("A") + 8'($urandom_range(25)));
				buf_char(CHAR_SPACE);
				add_value(0, $urandom_range(1, 9));
				send_line(1'b0);
			end else if (pick < 88) begin
				for (int i = $urandom_range(0, 90); i > 0; i--)
					buf_char(8'($urandom_range(255)));
				send_raw();
			end else if (pick < 94) begin
				if ($urandom_range(1))
					emit(CHAR_CR);
				emit(CHAR_LF);
			end else begin
				add_text(known_labels[$urandom_range(NUM_LABELS - 1)]);
				buf_char(CHAR_SPACE);
				add_value(3, $urandom_range(1, 12));
				send_line(1'b0);
			end
		end
	endtask

	task automatic wait_drained();
		while (tx_bytes.size() != 0 || rx_valid || expected_lines.size() != 0)
			@(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	task automatic write_interval(logic [7:0] v);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		while (!cfg_if.ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		m_interval = v;
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		directed_lines();
		wait_drained();

		write_interval(8'd0);
		random_lines(PHASE_BYTES);
		wait_drained();

		src_idle = 69;
		rcv_idle = 15;
		write_interval(8'd255);
		random_lines(PHASE_BYTES);
		wait_drained();

		write_interval(8'd1);
		random_lines(PHASE_BYTES);
		wait_drained();

		src_idle = 0;
		rcv_idle = 0;
		write_interval(8'($urandom_range(2, 9)));
		random_lines(PHASE_BYTES);
		wait_drained();

		write_interval(8'd2);
		random_lines(PHASE_BYTES);
		wait_drained();
		repeat (10) @(posedge clk);

		if (mismatches == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
